@@ hw/rtl/tkst_pkg.sv @@
// ----------------------------------------------------------------------------
// tkst_pkg
// Types and constants shared by the sorted score table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tkst_pkg;

  localparam int ENTRY_W = 64;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 4;
  localparam int LIM_W   = 5;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [LIM_W-1:0] MAX_ENTRIES_RESET = 5'd10;

  typedef struct packed {
    logic                      command;
    logic signed [ENTRY_W-1:0] new_value;
    logic [IDX_W-1:0]          read_index;
  } req_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] read_value;
    logic                      out_of_range;
    logic signed [ENTRY_W-1:0] top_value;
    logic [CNT_W-1:0]          entry_count;
  } rsp_t;

  // Per-cell control from the table controller.
  typedef struct packed {
    logic load;       // accepted add this cycle
    logic in_list;    // cell holds a live entry
    logic prev_take;  // left neighbor takes part in the shift
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tkst_cell.sv @@
// ----------------------------------------------------------------------------
// tkst_cell
// One slot of the sorted chain: holds an entry, compares it with the
// incoming value and takes either the new value or its left neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_cell
  import tkst_pkg::*;
(
  input  wire logic                      clk,
  input  wire cell_ctl_t                 ctl,
  input  wire logic signed [ENTRY_W-1:0] new_value,
  input  wire logic signed [ENTRY_W-1:0] prev_entry,
  output logic signed [ENTRY_W-1:0]      entry,
  output logic                           take
);

  logic less;

  // A dead slot always lies at or past the insertion point.
  assign less = entry < new_value;
  assign take = !ctl.in_list || less;

  always_ff @(posedge clk) begin
    if (ctl.load && take) begin
      entry <= ctl.prev_take ? prev_entry : new_value;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/top_k_sorted_score_table.sv @@
// ----------------------------------------------------------------------------
// top_k_sorted_score_table
// Descending sorted list of signed 64-bit values with add and read requests.
// ----------------------------------------------------------------------------
// The table keeps up to DEPTH signed values in descending order in a row of
// cells. An add request inserts new_value ahead of the first smaller entry
// (ties keep arrival order), drops the smallest entry once the list is full,
// then cuts the list to max_entries (0, or anything above DEPTH, means DEPTH).
// A read request returns the entry at read_index, or 0 with out_of_range set
// when the index is not below the count. Every response also carries the
// highest entry (0 when empty) and the count after the request.
// Throughput is one request per clock while the response side does not stall;
// the response is registered and appears in the cycle after the request is
// accepted. Every cell compares its entry with the incoming value in the same
// cycle and shifts or loads in place. The response register decouples the two
// sides: a new request is taken whenever that register is empty or draining.
// Write max_entries only while no request is in flight; a lowered limit is
// applied at the next add.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_sorted_score_table
  import tkst_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp,
  input  wire logic             cfg_we,
  input  wire logic [LIM_W-1:0] cfg_data
);

  localparam int CNT_IW = $clog2(DEPTH + 1);
  localparam int SEL_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = (CNT_IW > IDX_W) ? CNT_IW : IDX_W;
  localparam int LW     = (CNT_IW > LIM_W) ? CNT_IW : LIM_W;

  logic [LIM_W-1:0]          max_entries;
  logic [CNT_IW-1:0]         count;
  logic [CNT_IW-1:0]         count_next;
  logic                      accept;
  logic                      add;
  logic signed [ENTRY_W-1:0] entry [DEPTH];
  logic                      take  [DEPTH];
  cell_ctl_t                 ctl   [DEPTH];
  rsp_t                      rsp_next;

  // Stall the request side only while a response waits downstream.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign add       = accept && (req.command == CMD_ADD);

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg_we) begin
      max_entries <= cfg_data;
    end
  end

  // Row of cells; each hands its entry and shift flag to the right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctl[i].load    = add;
    assign ctl[i].in_list = CNT_IW'(i) < count;
    if (i == 0) begin : g_head
      assign ctl[i].prev_take = 1'b0;
      tkst_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .new_value  (req.new_value),
        .prev_entry (req.new_value),
        .entry      (entry[i]),
        .take       (take[i])
      );
    end else begin : g_body
      assign ctl[i].prev_take = take[i-1];
      tkst_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .new_value  (req.new_value),
        .prev_entry (entry[i-1]),
        .entry      (entry[i]),
        .take       (take[i])
      );
    end
  end

  // Count after an add: grow until full, then cut to the effective limit.
  always_comb begin
    logic [LW-1:0] lim;
    logic [LW-1:0] inc;
    lim = LW'(max_entries);
    if (max_entries == '0 || lim > LW'(DEPTH)) begin
      lim = LW'(DEPTH);
    end
    inc = LW'(count);
    if (count < CNT_IW'(DEPTH)) begin
      inc = inc + LW'(1);
    end
    if (inc > lim) begin
      inc = lim;
    end
    count_next = CNT_IW'(inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (add) begin
      count <= count_next;
    end
  end

  // Build the response from the state before the edge.
  always_comb begin
    logic idx_ok;
    idx_ok   = CMP_W'(req.read_index) < CMP_W'(count);
    rsp_next = '0;
    if (req.command == CMD_ADD) begin
      rsp_next.top_value   = take[0] ? req.new_value : entry[0];
      rsp_next.entry_count = CNT_W'(count_next);
    end else begin
      rsp_next.read_value   = idx_ok ? entry[SEL_W'(req.read_index)] : '0;
      rsp_next.out_of_range = !idx_ok;
      rsp_next.top_value    = (count != '0) ? entry[0] : '0;
      rsp_next.entry_count  = CNT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled; load on each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tkst_checker.sv @@
// ----------------------------------------------------------------------------
// tkst_checker
// Port-level checks for the sorted score table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_checker
  import tkst_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_stall,
  input wire req_t             req,
  input wire logic             rsp_valid,
  input wire logic             rsp_stall,
  input wire rsp_t             rsp,
  input wire logic             cfg_we,
  input wire logic [LIM_W-1:0] cfg_data
);

  logic unused_cfg;
  assign unused_cfg = cfg_we ^ (^cfg_data) ^ (^req.read_index) ^ (^req.new_value);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_of_range |-> rsp.read_value == '0)
    else $error("out-of-range read returned data");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.entry_count == '0 |-> rsp.top_value == '0)
    else $error("empty table reported a top value");

  a_add_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.command == CMD_ADD
      |=> rsp_valid && !rsp.out_of_range && rsp.read_value == '0)
    else $error("add request gave a wrong response");

endmodule

bind top_k_sorted_score_table tkst_checker u_tkst_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .cfg_we    (cfg_we),
  .cfg_data  (cfg_data)
);

`default_nettype wire
